### sv/cstk_pkg.sv
package cstk_pkg;

  localparam int DEPTH_DEF = 64;

  // command codes
  localparam logic [1:0] CMD_PUSH     = 2'd0;
  localparam logic [1:0] CMD_POP      = 2'd1;
  localparam logic [1:0] CMD_BRACKETS = 2'd2;
  localparam logic [1:0] CMD_FORMAT   = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MID   = 8'h43;

  // cell shift ops: down moves toward the far end, up moves toward the top cell
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_DOWN = 2'd1;
  localparam logic [1:0] OP_UP   = 2'd2;

  typedef struct packed {
    logic [1:0] main_op;
    logic [1:0] scr_op;
  } cell_ctrl_t;

endpackage

### sv/cstk_cell.sv
module cstk_cell
  import cstk_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] main_left,
  input  logic [7:0] main_right,
  input  logic [7:0] scr_left,
  input  logic [7:0] scr_right,
  output logic [7:0] main_q,
  output logic [7:0] scr_q
);

  always_ff @(posedge clk) begin
    case (ctrl.main_op)
      OP_DOWN: main_q <= main_left;
      OP_UP:   main_q <= main_right;
      default: main_q <= main_q;
    endcase
    case (ctrl.scr_op)
      OP_DOWN: scr_q <= scr_left;
      OP_UP:   scr_q <= scr_right;
      default: scr_q <= scr_q;
    endcase
  end

endmodule

### sv/cstk_chain.sv
module cstk_chain
  import cstk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] push_byte,
  output logic [7:0] main_top,
  output logic [7:0] scr_top
);

  logic [7:0] main_v [DEPTH];
  logic [7:0] scr_v  [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [7:0] ml, mr, sl, sr;
      // the top cell takes pushed bytes; the scratch row fills from the top main byte
      if (i == 0) begin : g_first
        assign ml = push_byte;
        assign sl = main_v[0];
      end else begin : g_mid
        assign ml = main_v[i-1];
        assign sl = scr_v[i-1];
      end
      // both rows close into rings when shifted up
      if (i == DEPTH - 1) begin : g_last
        assign mr = main_v[0];
        assign sr = scr_v[0];
      end else begin : g_inner
        assign mr = main_v[i+1];
        assign sr = scr_v[i+1];
      end
      cstk_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .main_left  (ml),
        .main_right (mr),
        .scr_left   (sl),
        .scr_right  (sr),
        .main_q     (main_v[i]),
        .scr_q      (scr_v[i])
      );
    end
  endgenerate

  assign main_top = main_v[0];
  assign scr_top  = scr_v[0];

endmodule

### sv/char_stack_with_checks.sv
// Byte stack of DEPTH entries held in a row of shift cells, top of stack in the first cell.
// Push and pop can follow back to back while each result is taken at once; a refused push
// (full) or an empty pop still returns one result item with its status. The bracket and format
// checks rotate the whole row twice through the top cell: once to copy the contents into the
// scratch row in reverse order, once to stream bottom-to-top against top-to-bottom, so a check
// holds off the input from its acceptance until both passes are done and its result is taken.
// Every command gives exactly one result item, held in an output register until taken.
module char_stack_with_checks
  import cstk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] pop_data, [9:8] status, [10] verdict,
                                      // [17:11] fill_level, [23:18] zero
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  localparam logic signed [CW:0] LVL_ONE = (CW+1)'(1);

  logic [1:0]        state, state_next;
  logic [AW-1:0]     step;
  logic [CW-1:0]     count;
  logic              chk_fmt;
  logic signed [CW:0] level, level_next;
  logic              fmt_ok, fmt_ok_next;

  logic [7:0]  out_data;
  logic [1:0]  out_status;
  logic        out_verdict;
  logic [6:0]  out_fill;

  cell_ctrl_t  ctrl;
  logic [7:0]  main_top, scr_top;

  logic in_acc, full, empty, last_step, in_range, at_mid;
  logic [CW-1:0] mid;

  assign s_axis_tready = (state == S_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = (count == CW'(DEPTH));
  assign empty         = (count == '0);
  assign last_step     = (step == AW'(DEPTH - 1));
  assign in_range      = (CW'(step) < count);
  assign mid           = (count - 1'b1) >> 1;
  assign at_mid        = (CW'(step) == mid);

  always_comb begin
    ctrl.main_op = OP_HOLD;
    ctrl.scr_op  = OP_HOLD;
    case (state)
      S_IDLE: begin
        if (in_acc && s_axis_tuser == CMD_PUSH && !full) ctrl.main_op = OP_DOWN;
        if (in_acc && s_axis_tuser == CMD_POP && !empty) ctrl.main_op = OP_UP;
      end
      S_FILL: begin
        ctrl.main_op = OP_UP;
        if (in_range) ctrl.scr_op = OP_DOWN;
      end
      S_SCAN: begin
        ctrl.main_op = OP_UP;
        ctrl.scr_op  = OP_UP;
      end
      default: ;
    endcase
  end

  cstk_chain #(.DEPTH(DEPTH)) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .push_byte (s_axis_tdata),
    .main_top  (main_top),
    .scr_top   (scr_top)
  );

  // scan step: scratch top streams bottom-to-top, main top streams top-to-bottom
  always_comb begin
    level_next  = level;
    fmt_ok_next = fmt_ok;
    if (in_range) begin
      if (level != -1) begin
        if (scr_top == CH_OPEN)       level_next = level + LVL_ONE;
        else if (scr_top == CH_CLOSE) level_next = level - LVL_ONE;
      end
      if (scr_top != main_top) fmt_ok_next = 1'b0;
      if (at_mid && main_top != CH_MID) fmt_ok_next = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc && (s_axis_tuser == CMD_BRACKETS || s_axis_tuser == CMD_FORMAT))
                state_next = S_FILL;
      S_FILL: if (last_step) state_next = S_SCAN;
      S_SCAN: if (last_step) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      step          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        step <= '0;
      end else begin
        step <= last_step ? '0 : step + 1'b1;
      end
      if (in_acc) begin
        case (s_axis_tuser)
          CMD_PUSH: if (!full) count <= count + 1'b1;
          CMD_POP:  if (!empty) count <= count - 1'b1;
          default: ;
        endcase
      end
      if (in_acc && (s_axis_tuser == CMD_PUSH || s_axis_tuser == CMD_POP)) begin
        m_axis_tvalid <= 1'b1;
      end else if (state == S_SCAN && last_step) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      chk_fmt <= (s_axis_tuser == CMD_FORMAT);
      level   <= '0;
      fmt_ok  <= count[0];
    end else if (state == S_SCAN) begin
      level  <= level_next;
      fmt_ok <= fmt_ok_next;
    end
    if (in_acc && s_axis_tuser == CMD_PUSH) begin
      out_data    <= 8'd0;
      out_status  <= full ? STAT_FULL : STAT_OK;
      out_verdict <= 1'b0;
      out_fill    <= full ? 7'(count) : 7'(count + 1'b1);
    end else if (in_acc && s_axis_tuser == CMD_POP) begin
      out_data    <= empty ? 8'd0 : main_top;
      out_status  <= empty ? STAT_EMPTY : STAT_OK;
      out_verdict <= 1'b0;
      out_fill    <= empty ? 7'(count) : 7'(count - 1'b1);
    end else if (state == S_SCAN && last_step) begin
      out_data    <= 8'd0;
      out_status  <= STAT_OK;
      out_verdict <= chk_fmt ? fmt_ok_next : (level_next == 0);
      out_fill    <= 7'(count);
    end
  end

  assign m_axis_tdata = {6'd0, out_fill, out_verdict, out_status, out_data};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("stack count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tuser == CMD_PUSH && !full) |=> (count == $past(count) + 1'b1))
    else $error("accepted push did not grow the stack");

  a_check_keeps: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(count))
    else $error("stack count moved during a check");

  a_verdict_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_verdict) |-> (out_status == STAT_OK && out_data == 8'd0))
    else $error("verdict set on a push or pop result");

endmodule
